@@ rtl/rrtp_pkg.sv @@
`timescale 1ns / 1ps

package rrtp_pkg;

    localparam int MAX_TEXT_BYTES  = 63;
    localparam int MIN_FRAME_BYTES = 5;
    localparam int BYTE_COUNT_W    = $clog2(MAX_TEXT_BYTES + 1);

    localparam int KEY_MAX = 6;
    localparam int PROG_W  = $clog2(KEY_MAX + 1);

    typedef logic [KEY_MAX-1:0][7:0] key_t;

    // Element zero holds the first character of the key.
    localparam key_t STATE_KEY = {8'h3A, 8'h65, 8'h74, 8'h61, 8'h74, 8'h53};
    localparam key_t DIST_KEY  = {8'h00, 8'h00, 8'h00, 8'h00, 8'h3A, 8'h64};
    localparam logic [PROG_W-1:0] STATE_KEY_LEN = PROG_W'(6);
    localparam logic [PROG_W-1:0] DIST_KEY_LEN  = PROG_W'(2);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_SIGN   = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_OK     = 3'd4;
    localparam logic [2:0] PH_FAIL   = 3'd5;

    localparam logic [31:0] MAG_CAP = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic step;
        logic clear;
    } rrtp_ctrl_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] value;
    } rrtp_num_t;

endpackage

@@ rtl/rrtp_if.sv @@
`timescale 1ns / 1ps

interface rrtp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_last;

    modport source (output valid, output rx_byte, output frame_last, input ready);
    modport sink (input valid, input rx_byte, input frame_last, output ready);
endinterface

interface rrtp_out_if;
    logic        valid;
    logic        ready;
    logic        updated;
    logic [31:0] range_dist;
    logic [7:0]  range_state;

    modport source (output valid, output updated, output range_dist, output range_state,
                    input ready);
    modport sink (input valid, input updated, input range_dist, input range_state,
                  output ready);
endinterface

@@ rtl/rrtp_matcher.sv @@
`timescale 1ns / 1ps

module rrtp_matcher
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  rrtp_pkg::rrtp_ctrl_t        ctrl,
    input  logic [7:0]                  c,
    input  rrtp_pkg::key_t              key,
    input  logic [rrtp_pkg::PROG_W-1:0] key_len,
    output rrtp_pkg::rrtp_num_t         num
);

    logic [rrtp_pkg::PROG_W-1:0] prog_reg;
    logic [rrtp_pkg::PROG_W-1:0] prog_next;
    logic [2:0]                  phase_reg;
    logic [2:0]                  phase_next;
    logic [31:0]                 acc_reg;
    logic [31:0]                 acc_next;
    logic                        neg_reg;
    logic                        neg_next;

    always_comb
    begin
        logic       digit;
        logic       space;
        logic       take;
        logic [7:0] key_char;
        logic [35:0] mag;

        prog_next  = prog_reg;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        take       = 1'b0;
        digit      = (c >= 8'h30) && (c <= 8'h39);
        space      = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
        key_char   = 8'h00;
        for (int i = 0; i < rrtp_pkg::KEY_MAX; i++)
        begin
            if (prog_reg == rrtp_pkg::PROG_W'(i))
            begin
                key_char = key[i];
            end
        end
        mag = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {32'd0, c[3:0]};

        if (ctrl.step)
        begin
            if (phase_reg == rrtp_pkg::PH_IDLE)
            begin
                if ((prog_reg < key_len) && (c == key_char))
                begin
                    prog_next = prog_reg + rrtp_pkg::PROG_W'(1);
                end
                else
                begin
                    prog_next = (c == key[0]) ? rrtp_pkg::PROG_W'(1) : '0;
                end
                if (prog_next >= key_len)
                begin
                    phase_next = rrtp_pkg::PH_SKIP;
                end
            end
            else
            begin
                case (phase_reg)
                    rrtp_pkg::PH_SKIP:
                    begin
                        if (space)
                        begin
                            take = 1'b0;
                        end
                        else if ((c == 8'h2B) || (c == 8'h2D))
                        begin
                            neg_next   = (c == 8'h2D);
                            phase_next = rrtp_pkg::PH_SIGN;
                        end
                        else
                        begin
                            take = 1'b1;
                        end
                    end
                    rrtp_pkg::PH_SIGN:
                    begin
                        take = 1'b1;
                    end
                    rrtp_pkg::PH_DIGITS:
                    begin
                        if (!digit)
                        begin
                            phase_next = rrtp_pkg::PH_OK;
                        end
                        else
                        begin
                            take = 1'b1;
                        end
                    end
                    default:
                    begin
                        take = 1'b0;
                    end
                endcase
                if (take)
                begin
                    if (!digit)
                    begin
                        phase_next = rrtp_pkg::PH_FAIL;
                    end
                    else
                    begin
                        acc_next   = (mag > {4'd0, rrtp_pkg::MAG_CAP}) ?
                                     rrtp_pkg::MAG_CAP : mag[31:0];
                        phase_next = rrtp_pkg::PH_DIGITS;
                    end
                end
            end
        end
    end

    // The result reflects the state after the current byte, so the frame's last byte counts.
    always_comb
    begin
        num.ok = (phase_next == rrtp_pkg::PH_DIGITS) || (phase_next == rrtp_pkg::PH_OK);
        if (neg_next)
        begin
            num.value = 32'd0 - acc_next;
        end
        else
        begin
            num.value = acc_next[31] ? rrtp_pkg::POS_MAX : acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_reg  <= '0;
            phase_reg <= rrtp_pkg::PH_IDLE;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            prog_reg  <= '0;
            phase_reg <= rrtp_pkg::PH_IDLE;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            prog_reg  <= prog_next;
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg <= rrtp_pkg::MAG_CAP))
        else $error("Number magnitude exceeded its saturation cap.");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> (phase_reg == rrtp_pkg::PH_IDLE) && (prog_reg == '0))
        else $error("Matcher did not return to idle after the frame ended.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == rrtp_pkg::PH_IDLE) |-> (acc_reg == '0) && !neg_reg)
        else $error("Number state changed before the key was found.");

endmodule

@@ rtl/range_report_text_parser_core.sv @@
`timescale 1ns / 1ps

// Parses range reports one byte per item. A byte is captured in the input register, and the
// matcher update runs between it and the result register, so a frame's result is loaded into
// the result register as its last byte leaves the input register. A new byte is accepted in
// every clock cycle unless the result register holds the input side back, which only it can:
// a frame's last byte waits while a previous result has not been taken; others always pass.
module range_report_text_parser_core
(
    input logic        clk,
    input logic        rst_n,
    rrtp_in_if.sink    rx,
    rrtp_out_if.source result
);

    logic                              s1_valid_reg;
    logic [7:0]                        s1_byte_reg;
    logic                              s1_last_reg;
    logic                              advance;
    logic                              fire;
    logic                              frame_end;
    logic                              in_text;
    logic [rrtp_pkg::BYTE_COUNT_W-1:0] byte_count_reg;
    logic [rrtp_pkg::BYTE_COUNT_W-1:0] byte_count_next;
    logic                              text_ended_reg;
    logic                              text_ended_next;
    logic                              frame_ok;
    logic [31:0]                       held_distance_reg;
    logic [7:0]                        held_state_reg;
    logic                              out_valid_reg;
    logic                              out_updated_reg;
    logic [31:0]                       out_distance_reg;
    logic [7:0]                        out_state_reg;
    rrtp_pkg::rrtp_ctrl_t              ctrl;
    rrtp_pkg::rrtp_num_t               state_num;
    rrtp_pkg::rrtp_num_t               dist_num;

    assign advance   = !s1_last_reg || !out_valid_reg || result.ready;
    assign fire      = s1_valid_reg && advance;
    assign frame_end = fire && s1_last_reg;
    assign rx.ready  = !s1_valid_reg || advance;

    assign in_text    = !text_ended_reg &&
                        (byte_count_reg < rrtp_pkg::BYTE_COUNT_W'(rrtp_pkg::MAX_TEXT_BYTES));
    assign ctrl.step  = fire && in_text && (s1_byte_reg != 8'h00);
    assign ctrl.clear = frame_end;

    assign text_ended_next = text_ended_reg || (fire && in_text && (s1_byte_reg == 8'h00));
    assign byte_count_next = (fire && (byte_count_reg <
                              rrtp_pkg::BYTE_COUNT_W'(rrtp_pkg::MAX_TEXT_BYTES))) ?
                             byte_count_reg + rrtp_pkg::BYTE_COUNT_W'(1) : byte_count_reg;

    assign frame_ok = (byte_count_next >= rrtp_pkg::BYTE_COUNT_W'(rrtp_pkg::MIN_FRAME_BYTES)) &&
                      state_num.ok && dist_num.ok &&
                      (state_num.value != 32'hFFFF_FFFF) && (dist_num.value != 32'hFFFF_FFFF);

    rrtp_matcher u_state_matcher
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .c       (s1_byte_reg),
        .key     (rrtp_pkg::STATE_KEY),
        .key_len (rrtp_pkg::STATE_KEY_LEN),
        .num     (state_num)
    );

    rrtp_matcher u_dist_matcher
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .c       (s1_byte_reg),
        .key     (rrtp_pkg::DIST_KEY),
        .key_len (rrtp_pkg::DIST_KEY_LEN),
        .num     (dist_num)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            s1_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            s1_byte_reg <= rx.rx_byte;
            s1_last_reg <= rx.frame_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            text_ended_reg    <= 1'b0;
            held_distance_reg <= '0;
            held_state_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (frame_end)
            begin
                byte_count_reg <= '0;
                text_ended_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
                if (frame_ok)
                begin
                    held_distance_reg <= dist_num.value;
                    held_state_reg    <= state_num.value[7:0];
                end
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                text_ended_reg <= text_ended_next;
                if (result.ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_end)
        begin
            out_updated_reg  <= frame_ok;
            out_distance_reg <= frame_ok ? dist_num.value : held_distance_reg;
            out_state_reg    <= frame_ok ? state_num.value[7:0] : held_state_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.updated     = out_updated_reg;
    assign result.range_dist  = out_distance_reg;
    assign result.range_state = out_state_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> out_valid_reg && (byte_count_reg == '0) && !text_ended_reg)
        else $error("Frame end did not load a result and clear the frame state.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_distance_reg == held_distance_reg) &&
                          (out_state_reg == held_state_reg))
        else $error("Pending result differs from the held values.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_last_reg) |-> rx.ready)
        else $error("A byte that does not end a frame stalled the input.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !frame_end)
        else $error("A result was overwritten before it was taken.");

endmodule
